// ===== src/assert_macros.svh =====
// Concurrent assertion helpers; each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/wadx_pkg.sv =====
`timescale 1ns / 1ps
package wadx_pkg;

	localparam int PERIOD         = 14;
	localparam int PRICE_BITS     = 32;
	localparam int FRAC_BITS      = 16;
	localparam int Q16_BITS       = PRICE_BITS + FRAC_BITS;
	localparam int SMOOTH_BITS    = 56;
	localparam int INDEX_BITS     = 24;
	localparam int DI_BITS        = 23;
	localparam int SAT_SHIFT      = DI_BITS - FRAC_BITS;
	localparam int COUNT_BITS     = 6;
	localparam int COUNT_MAX      = 2 ** COUNT_BITS - 1;
	localparam int WIDE_BITS      = 64;
	localparam int DIGIT_BITS     = 4;
	localparam int DIGITS         = WIDE_BITS / DIGIT_BITS;
	localparam int DSTEP_BITS     = $clog2(DIGITS + 1);
	localparam int QSTEP_BITS     = $clog2(DI_BITS + 1);
	localparam int REM_BITS       = $clog2(PERIOD);
	localparam int VAL_BITS       = REM_BITS + DIGIT_BITS;
	localparam int LANES          = 3;
	localparam int DX_SCALE       = 100;
	localparam int CFG_IDX_BITS   = 2;
	localparam int WARMUP_RESET   = 40;
	localparam int FALLBACK_RESET = 1310720;

	typedef logic [WIDE_BITS-1:0] wide_t;
	typedef wide_t [LANES-1:0] lanes_t;

	typedef struct packed {
		logic [PRICE_BITS-1:0] high_price;
		logic [PRICE_BITS-1:0] low_price;
		logic [PRICE_BITS-1:0] close_price;
		logic                  first_bar;
	} bar_t;

	typedef struct packed {
		logic [DI_BITS-1:0] adx_value;
		logic               warmed_up;
	} adx_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_WARMUP   = 2'd0,
		REG_FALLBACK = 2'd1
	} cfg_reg_t;

	typedef enum logic [4:0] {
		DP_NONE,
		DP_CAPTURE,
		DP_SEED,
		DP_RAW,
		DP_SUM,
		DP_W_START,
		DP_W_STORE,
		DP_PDI_START,
		DP_PDI_STORE,
		DP_NDI_START,
		DP_NDI_STORE,
		DP_DX_START,
		DP_DX_STORE,
		DP_IX_SET,
		DP_IX_START,
		DP_IX_STORE,
		DP_COUNT,
		DP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic first;
		logic summing;
		logic at_period;
		logic cdiv_done;
		logic qdiv_done;
		logic out_free;
	} dp_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RAW,
		ST_SUM,
		ST_W_START,
		ST_W_WAIT,
		ST_PDI_START,
		ST_PDI_WAIT,
		ST_NDI_START,
		ST_NDI_WAIT,
		ST_DX_START,
		ST_DX_WAIT,
		ST_IX_SEL,
		ST_IX_WAIT,
		ST_COUNT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [DIGIT_BITS-1:0] q;
		logic [REM_BITS-1:0]   r;
	} digit_res_t;

	function automatic digit_res_t digit_div(input logic [VAL_BITS-1:0] v);
		digit_res_t res;
		logic [VAL_BITS-1:0] left;
		res.q = '0;
		for (int k = 1; k < 2 ** DIGIT_BITS; k++) begin
			if (v >= VAL_BITS'(k * PERIOD)) begin
				res.q = DIGIT_BITS'(k);
			end
		end
		left = v - VAL_BITS'(res.q) * VAL_BITS'(PERIOD);
		res.r = left[REM_BITS-1:0];
		return res;
	endfunction

endpackage

// ===== src/wilder_adx_tracker_top.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_data (bar_t)
// out     | output    | out_valid/out_stall| out_data (adx_t)
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A series-start bar clears the sums, a summing bar adds to them.
// The smoothed bar runs the 23-step quotient divider three times and the 16-digit
// divide-by-period unit once or twice (once at the period bar), one after another.
// One request is in flight at a time; the next is taken once the result is loaded.
// A held result stalls only the final load; arst_n resets the FSM and the sums.
module wilder_adx_tracker_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  wadx_pkg::bar_t                    in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output wadx_pkg::adx_t                    out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wadx_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [wadx_pkg::DI_BITS-1:0]      cfg_data
);
	import wadx_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	wadx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	wadx_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

// ===== src/wadx_qdiv.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wadx_qdiv (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  wadx_pkg::wide_t                    num,
	input  logic [wadx_pkg::SMOOTH_BITS-1:0]   den,
	output logic                               done,
	output logic [wadx_pkg::DI_BITS-1:0]       quo
);
	import wadx_pkg::*;

	localparam int CMP_BITS = WIDE_BITS + 1;

	logic                   busy_q;
	logic                   done_q;
	logic [QSTEP_BITS-1:0]  cnt_q;
	logic [SMOOTH_BITS-1:0] den_q;
	logic [SMOOTH_BITS-1:0] rem_q;
	logic [DI_BITS-1:0]     bits_q;
	logic [DI_BITS-1:0]     quo_q;

	logic                   den_zero;
	logic                   sat;
	logic [SMOOTH_BITS:0]   rem2;
	logic [SMOOTH_BITS:0]   diff;
	logic                   ge;

	assign den_zero = (den == '0);
	assign sat      = CMP_BITS'(num) >= CMP_BITS'({den, {SAT_SHIFT{1'b0}}});
	assign rem2     = {rem_q, bits_q[DI_BITS-1]};
	assign diff     = rem2 - {1'b0, den_q};
	assign ge       = (rem2 >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den_zero || sat) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= QSTEP_BITS'(DI_BITS);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == QSTEP_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= den;
			rem_q  <= num[SMOOTH_BITS+SAT_SHIFT-1:SAT_SHIFT];
			bits_q <= {num[SAT_SHIFT-1:0], {FRAC_BITS{1'b0}}};
			if (den_zero) begin
				quo_q <= '0;
			end else if (sat) begin
				quo_q <= '1;
			end
		end else if (busy_q) begin
			rem_q  <= ge ? diff[SMOOTH_BITS-1:0] : rem2[SMOOTH_BITS-1:0];
			quo_q  <= {quo_q[DI_BITS-2:0], ge};
			bits_q <= bits_q << 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	`ASSERT_NEXT(a_start_runs, start, busy_q || done_q, "divider start did not take")
	`ASSERT_NOW(a_done_idle, done_q, !busy_q, "divider done while busy")

endmodule

// ===== src/wadx_cdiv.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wadx_cdiv (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  wadx_pkg::lanes_t num,
	output logic             done,
	output wadx_pkg::lanes_t quo
);
	import wadx_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [DSTEP_BITS-1:0] cnt_q;
	lanes_t                acc_q;
	logic [REM_BITS-1:0]   rem_q [LANES];
	digit_res_t            res   [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			res[l] = digit_div({rem_q[l], acc_q[l][WIDE_BITS-1 -: DIGIT_BITS]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DSTEP_BITS'(DIGITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DSTEP_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (start) begin
				acc_q[l] <= num[l];
				rem_q[l] <= '0;
			end else if (busy_q) begin
				acc_q[l] <= {acc_q[l][WIDE_BITS-DIGIT_BITS-1:0], res[l].q};
				rem_q[l] <= res[l].r;
			end
		end
	end

	assign done = done_q;
	assign quo  = acc_q;

	`ASSERT_NOW(a_cdone_idle, done_q, !busy_q, "constant divider done while busy")
	`ASSERT_NEXT(a_cstart_busy, start, busy_q, "constant divider start did not take")

endmodule

// ===== src/wadx_datapath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wadx_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wadx_pkg::dp_cmd_t                   cmd,
	output wadx_pkg::dp_status_t                status,
	input  wadx_pkg::bar_t                      in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output wadx_pkg::adx_t                      out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wadx_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [wadx_pkg::DI_BITS-1:0]        cfg_data
);
	import wadx_pkg::*;

	localparam int DIFF_BITS = PRICE_BITS + 2;

	bar_t                   in_q;
	logic [PRICE_BITS-1:0]  prev_high_q, prev_low_q, prev_close_q;
	logic [PRICE_BITS-1:0]  tr_q, pdm_q, ndm_q;
	logic [SMOOTH_BITS-1:0] range_q, plus_q, minus_q;
	logic [INDEX_BITS-1:0]  index_q;
	logic [DI_BITS-1:0]     pdi_q, ndi_q, dx_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic [COUNT_BITS-1:0]  warmup_q;
	logic [DI_BITS-1:0]     fallback_q;
	logic                   out_valid_q;
	adx_t                   out_q;

	logic signed [DIFF_BITS-1:0] h_s, l_s, ph_s, pl_s, pc_s;
	logic signed [DIFF_BITS-1:0] t1, t2, t3, tr_s, up, down, pdm_s, ndm_s;
	logic [Q16_BITS-1:0]         tr16, pdm16, ndm16;
	logic [SMOOTH_BITS:0]        sum_tr, sum_p, sum_n;
	logic [DI_BITS-1:0]          di_diff;
	logic [DI_BITS:0]            di_sum;
	wide_t                       ix_num;
	lanes_t                      w_num, cdiv_num, cdiv_quo;
	logic                        cdiv_start, cdiv_done;
	wide_t                       qdiv_num;
	logic [SMOOTH_BITS-1:0]      qdiv_den;
	logic                        qdiv_start, qdiv_done;
	logic [DI_BITS-1:0]          qdiv_quo;
	logic                        warm;

	always_comb begin
		h_s  = signed'(DIFF_BITS'(in_q.high_price));
		l_s  = signed'(DIFF_BITS'(in_q.low_price));
		ph_s = signed'(DIFF_BITS'(prev_high_q));
		pl_s = signed'(DIFF_BITS'(prev_low_q));
		pc_s = signed'(DIFF_BITS'(prev_close_q));
		t1   = h_s - l_s;
		t2   = h_s - pc_s;
		t3   = l_s - pc_s;
		if (t2 < 0) begin
			t2 = -t2;
		end
		if (t3 < 0) begin
			t3 = -t3;
		end
		tr_s = t1;
		if (t2 > tr_s) begin
			tr_s = t2;
		end
		if (t3 > tr_s) begin
			tr_s = t3;
		end
		up    = h_s - ph_s;
		down  = pl_s - l_s;
		pdm_s = (up > down && up > 0) ? up : '0;
		ndm_s = (down > up && down > 0) ? down : '0;
	end

	assign tr16  = {tr_q, {FRAC_BITS{1'b0}}};
	assign pdm16 = {pdm_q, {FRAC_BITS{1'b0}}};
	assign ndm16 = {ndm_q, {FRAC_BITS{1'b0}}};

	assign sum_tr = {1'b0, range_q} + (SMOOTH_BITS+1)'(tr16);
	assign sum_p  = {1'b0, plus_q} + (SMOOTH_BITS+1)'(pdm16);
	assign sum_n  = {1'b0, minus_q} + (SMOOTH_BITS+1)'(ndm16);

	assign w_num[0] = WIDE_BITS'(range_q) * WIDE_BITS'(PERIOD - 1) + WIDE_BITS'(tr16)
		+ WIDE_BITS'(PERIOD / 2);
	assign w_num[1] = WIDE_BITS'(plus_q) * WIDE_BITS'(PERIOD - 1) + WIDE_BITS'(pdm16)
		+ WIDE_BITS'(PERIOD / 2);
	assign w_num[2] = WIDE_BITS'(minus_q) * WIDE_BITS'(PERIOD - 1) + WIDE_BITS'(ndm16)
		+ WIDE_BITS'(PERIOD / 2);
	assign ix_num = WIDE_BITS'(index_q) * WIDE_BITS'(PERIOD - 1) + WIDE_BITS'(dx_q)
		+ WIDE_BITS'(PERIOD / 2);

	always_comb begin
		cdiv_num = w_num;
		if (cmd.op == DP_IX_START) begin
			cdiv_num    = '0;
			cdiv_num[0] = ix_num;
		end
	end
	assign cdiv_start = (cmd.op == DP_W_START) || (cmd.op == DP_IX_START);

	assign di_diff = (pdi_q > ndi_q) ? pdi_q - ndi_q : ndi_q - pdi_q;
	assign di_sum  = {1'b0, pdi_q} + {1'b0, ndi_q};

	always_comb begin
		qdiv_num = WIDE_BITS'(plus_q) * WIDE_BITS'(DX_SCALE);
		qdiv_den = range_q;
		if (cmd.op == DP_NDI_START) begin
			qdiv_num = WIDE_BITS'(minus_q) * WIDE_BITS'(DX_SCALE);
		end else if (cmd.op == DP_DX_START) begin
			qdiv_num = WIDE_BITS'(di_diff) * WIDE_BITS'(DX_SCALE);
			qdiv_den = SMOOTH_BITS'(di_sum);
		end
	end
	assign qdiv_start = (cmd.op == DP_PDI_START) || (cmd.op == DP_NDI_START)
		|| (cmd.op == DP_DX_START);

	wadx_cdiv u_cdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cdiv_start),
		.num    (cdiv_num),
		.done   (cdiv_done),
		.quo    (cdiv_quo)
	);

	wadx_qdiv u_qdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (qdiv_start),
		.num    (qdiv_num),
		.den    (qdiv_den),
		.done   (qdiv_done),
		.quo    (qdiv_quo)
	);

	assign warm = (count_q >= warmup_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_high_q  <= '0;
			prev_low_q   <= '0;
			prev_close_q <= '0;
			range_q      <= '0;
			plus_q       <= '0;
			minus_q      <= '0;
			index_q      <= '0;
			count_q      <= '0;
			warmup_q     <= COUNT_BITS'(WARMUP_RESET);
			fallback_q   <= DI_BITS'(FALLBACK_RESET);
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_WARMUP) begin
					warmup_q <= cfg_data[COUNT_BITS-1:0];
				end else if (cfg_index == REG_FALLBACK) begin
					fallback_q <= cfg_data;
				end
			end
			if (cmd.op == DP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd.op)
				DP_SEED: begin
					range_q <= '0;
					plus_q  <= '0;
					minus_q <= '0;
					index_q <= '0;
					count_q <= COUNT_BITS'(1);
				end
				DP_SUM: begin
					range_q <= sum_tr[SMOOTH_BITS] ? '1 : sum_tr[SMOOTH_BITS-1:0];
					plus_q  <= sum_p[SMOOTH_BITS] ? '1 : sum_p[SMOOTH_BITS-1:0];
					minus_q <= sum_n[SMOOTH_BITS] ? '1 : sum_n[SMOOTH_BITS-1:0];
				end
				DP_W_STORE: begin
					range_q <= cdiv_quo[0][SMOOTH_BITS-1:0];
					plus_q  <= cdiv_quo[1][SMOOTH_BITS-1:0];
					minus_q <= cdiv_quo[2][SMOOTH_BITS-1:0];
				end
				DP_IX_SET: begin
					index_q <= INDEX_BITS'(dx_q);
				end
				DP_IX_STORE: begin
					index_q <= cdiv_quo[0][INDEX_BITS-1:0];
				end
				DP_COUNT: begin
					if (count_q != COUNT_BITS'(COUNT_MAX)) begin
						count_q <= count_q + 1'b1;
					end
				end
				DP_FINISH: begin
					prev_high_q  <= in_q.high_price;
					prev_low_q   <= in_q.low_price;
					prev_close_q <= in_q.close_price;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_CAPTURE: in_q <= in_data;
			DP_RAW: begin
				tr_q  <= tr_s[PRICE_BITS-1:0];
				pdm_q <= pdm_s[PRICE_BITS-1:0];
				ndm_q <= ndm_s[PRICE_BITS-1:0];
			end
			DP_PDI_STORE: pdi_q <= qdiv_quo;
			DP_NDI_STORE: ndi_q <= qdiv_quo;
			DP_DX_STORE:  dx_q  <= qdiv_quo;
			DP_FINISH: begin
				out_q.warmed_up <= warm;
				out_q.adx_value <= warm ? index_q[DI_BITS-1:0] : fallback_q;
			end
			default: begin
			end
		endcase
	end

	assign status.first     = in_q.first_bar || (count_q == '0);
	assign status.summing   = (count_q < COUNT_BITS'(PERIOD));
	assign status.at_period = (count_q == COUNT_BITS'(PERIOD));
	assign status.cdiv_done = cdiv_done;
	assign status.qdiv_done = qdiv_done;
	assign status.out_free  = !out_valid_q || !out_stall;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_NEXT(a_seed_count, cmd.op == DP_SEED, count_q == COUNT_BITS'(1),
		"series start did not set bar count")
	`ASSERT_NOW(a_finish_free, cmd.op == DP_FINISH, !out_valid_q || !out_stall,
		"result loaded over a held result")

endmodule

// ===== src/wadx_ctrl.sv =====
`timescale 1ns / 1ps
module wadx_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  wadx_pkg::dp_status_t status,
	output wadx_pkg::dp_cmd_t    cmd
);
	import wadx_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = DP_NONE;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op  = DP_CAPTURE;
					state_d = ST_RAW;
				end
			end
			ST_RAW: begin
				if (status.first) begin
					cmd.op  = DP_SEED;
					state_d = ST_FINISH;
				end else begin
					cmd.op  = DP_RAW;
					state_d = status.summing ? ST_SUM : ST_W_START;
				end
			end
			ST_SUM: begin
				cmd.op  = DP_SUM;
				state_d = ST_COUNT;
			end
			ST_W_START: begin
				cmd.op  = DP_W_START;
				state_d = ST_W_WAIT;
			end
			ST_W_WAIT: begin
				if (status.cdiv_done) begin
					cmd.op  = DP_W_STORE;
					state_d = ST_PDI_START;
				end
			end
			ST_PDI_START: begin
				cmd.op  = DP_PDI_START;
				state_d = ST_PDI_WAIT;
			end
			ST_PDI_WAIT: begin
				if (status.qdiv_done) begin
					cmd.op  = DP_PDI_STORE;
					state_d = ST_NDI_START;
				end
			end
			ST_NDI_START: begin
				cmd.op  = DP_NDI_START;
				state_d = ST_NDI_WAIT;
			end
			ST_NDI_WAIT: begin
				if (status.qdiv_done) begin
					cmd.op  = DP_NDI_STORE;
					state_d = ST_DX_START;
				end
			end
			ST_DX_START: begin
				cmd.op  = DP_DX_START;
				state_d = ST_DX_WAIT;
			end
			ST_DX_WAIT: begin
				if (status.qdiv_done) begin
					cmd.op  = DP_DX_STORE;
					state_d = ST_IX_SEL;
				end
			end
			ST_IX_SEL: begin
				if (status.at_period) begin
					cmd.op  = DP_IX_SET;
					state_d = ST_COUNT;
				end else begin
					cmd.op  = DP_IX_START;
					state_d = ST_IX_WAIT;
				end
			end
			ST_IX_WAIT: begin
				if (status.cdiv_done) begin
					cmd.op  = DP_IX_STORE;
					state_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				cmd.op  = DP_COUNT;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.op  = DP_FINISH;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
